@@ design/bitmap_allocator_fifo_victim_top_macros.svh @@
// Assertion macros shared by the frame allocator modules.
// Depends on nothing; a module that uses them has ports named i_clk and i_rst_n.
`ifndef BITMAP_ALLOCATOR_FIFO_VICTIM_TOP_MACROS_SVH
`define BITMAP_ALLOCATOR_FIFO_VICTIM_TOP_MACROS_SVH

`ifndef SYNTHESIS

// A property that must hold at every clock edge outside reset.
`define BAFV_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// A condition that must never be seen outside reset.
`define BAFV_NEVER(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);

`else

`define BAFV_ASSERT(label, prop, msg)
`define BAFV_NEVER(label, cond, msg)

`endif

`endif

@@ design/bafv_pkg.sv @@
// Shared types, codes and default sizes of the frame allocator.
// Used by bafv_engine, the top level and the benches; depends on nothing.
package bafv_pkg;

    // Default sizes, handed to the top-level parameters.
    localparam int NUM_BITS_DEF    = 128;
    localparam int WORD_BITS_DEF   = 32;
    localparam int OWNER_WIDTH_DEF = 8;

    // Action codes carried in the input tuser.
    localparam logic [2:0] ACT_MARK  = 3'd0;
    localparam logic [2:0] ACT_CLEAR = 3'd1;
    localparam logic [2:0] ACT_TEST  = 3'd2;
    localparam logic [2:0] ACT_ALLOC = 3'd3;
    localparam logic [2:0] ACT_POP   = 3'd4;

    // Status codes carried in the output tuser.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    // One request word.
    typedef struct packed {
        logic [2:0] action;
        logic [7:0] bit_index;
        logic [7:0] owner_id;
    } t_item;

    // One response word.
    typedef struct packed {
        logic [6:0] result_index;
        logic [7:0] result_owner;
        logic       bit_value;
        logic [7:0] free_count;
        logic [1:0] status;
    } t_result;

endpackage

@@ design/bafv_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// Depends on nothing.
module bafv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                     i_wdata,
    input  logic                                 i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port; the data holds while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/bafv_ffz.sv @@
// Finds the lowest clear bit of one bitmap word.
// Uses nothing from the package.
module bafv_ffz #(
    parameter int WORD_BITS = 32
) (
    input  logic [WORD_BITS-1:0]         i_word,
    output logic                         o_found,
    output logic [$clog2(WORD_BITS)-1:0] o_pos
);

    localparam int BW = $clog2(WORD_BITS);

    // Priority pick from the top down so that the lowest clear bit wins.
    always_comb begin
        o_pos = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--) begin
            if (!i_word[b]) begin
                o_pos = BW'(b);
            end
        end
        o_found = ~&i_word;
    end

endmodule

@@ design/bafv_engine.sv @@
// Sequencer of the frame allocator: bitmap, owner/queued and victim FIFO memories
// with their read-modify-write control. Depends on bafv_pkg, bafv_ram, bafv_ffz.
`include "bitmap_allocator_fifo_victim_top_macros.svh"

module bafv_engine
    import bafv_pkg::*;
#(
    parameter int NUM_BITS    = NUM_BITS_DEF,
    parameter int WORD_BITS   = WORD_BITS_DEF,
    parameter int OWNER_WIDTH = OWNER_WIDTH_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_item_valid,
    output logic    o_item_ready,
    input  t_item   i_item,
    output logic    o_res_valid,
    input  logic    i_res_ready,
    output t_result o_res
);

    localparam int IW        = $clog2(NUM_BITS);
    localparam int BW        = $clog2(WORD_BITS);
    localparam int XW        = IW + BW;
    localparam int NUM_WORDS = (NUM_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int WA        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int FW        = $clog2(NUM_BITS + 1);
    localparam int OQW       = OWNER_WIDTH + 1;
    localparam int LAST_BITS = NUM_BITS - (NUM_WORDS - 1) * WORD_BITS;
    localparam logic [WA-1:0] LAST_WORD = WA'(NUM_WORDS - 1);
    localparam logic [IW-1:0] LAST_IDX  = IW'(NUM_BITS - 1);
    // Bits of the last word beyond the map count as used during a scan.
    localparam logic [WORD_BITS-1:0] PAD_MASK =
        ~({WORD_BITS{1'b1}} >> (WORD_BITS - LAST_BITS));
    localparam logic [WORD_BITS-1:0] ONE_W = WORD_BITS'(1);

    // Sequencer states.
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_BIT  = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_AWR  = 3'd3;
    localparam logic [2:0] S_POPA = 3'd4;
    localparam logic [2:0] S_POPB = 3'd5;
    localparam logic [2:0] S_FIN  = 3'd6;

    logic [2:0]             r_state, n_state;
    logic [2:0]             r_act, n_act;
    logic [7:0]             r_idx, n_idx;
    logic [OWNER_WIDTH-1:0] r_owner, n_owner;
    logic [WA-1:0]          r_word, n_word;
    logic [BW-1:0]          r_bitpos, n_bitpos;
    logic [IW-1:0]          r_vidx, n_vidx;
    logic [IW-1:0]          r_head, n_head;
    logic [IW-1:0]          r_tail, n_tail;
    logic [FW-1:0]          r_fill, n_fill;
    logic [FW-1:0]          r_free, n_free;
    logic [1:0]             r_fin_status, n_fin_status;
    logic [6:0]             r_fin_index, n_fin_index;
    logic                   r_clearing;
    logic [IW-1:0]          r_clr_cnt;

    // Memory ports.
    logic                   bm_we, bm_re;
    logic [WA-1:0]          bm_waddr, bm_raddr;
    logic [WORD_BITS-1:0]   bm_wdata, bm_rdata;
    logic                   oq_we, oq_re;
    logic [IW-1:0]          oq_waddr, oq_raddr;
    logic [OQW-1:0]         oq_wdata, oq_rdata;
    logic                   vf_we, vf_re;
    logic [IW-1:0]          vf_waddr, vf_raddr;
    logic [IW-1:0]          vf_wdata, vf_rdata;

    logic [XW-1:0]          in_x, vf_x;
    logic [WORD_BITS-1:0]   scan_word;
    logic                   scan_found;
    logic [BW-1:0]          scan_pos;
    logic                   bit_now;
    logic                   out_go;
    logic                   item_take;

    bafv_ram #(.WIDTH(WORD_BITS), .DEPTH(NUM_WORDS)) u_bitmap (
        .i_clk   (i_clk),
        .i_we    (bm_we),
        .i_waddr (bm_waddr),
        .i_wdata (bm_wdata),
        .i_re    (bm_re),
        .i_raddr (bm_raddr),
        .o_rdata (bm_rdata)
    );

    // Each entry holds the queued mark above the owner tag.
    bafv_ram #(.WIDTH(OQW), .DEPTH(NUM_BITS)) u_owner (
        .i_clk   (i_clk),
        .i_we    (oq_we),
        .i_waddr (oq_waddr),
        .i_wdata (oq_wdata),
        .i_re    (oq_re),
        .i_raddr (oq_raddr),
        .o_rdata (oq_rdata)
    );

    bafv_ram #(.WIDTH(IW), .DEPTH(NUM_BITS)) u_victim (
        .i_clk   (i_clk),
        .i_we    (vf_we),
        .i_waddr (vf_waddr),
        .i_wdata (vf_wdata),
        .i_re    (vf_re),
        .i_raddr (vf_raddr),
        .o_rdata (vf_rdata)
    );

    // Lowest free bit of the word under scan.
    assign scan_word = (r_word == LAST_WORD) ? (bm_rdata | PAD_MASK) : bm_rdata;

    bafv_ffz #(.WORD_BITS(WORD_BITS)) u_ffz (
        .i_word  (scan_word),
        .o_found (scan_found),
        .o_pos   (scan_pos)
    );

    assign in_x    = XW'(i_item.bit_index);
    assign vf_x    = XW'(vf_rdata);
    assign bit_now = bm_rdata[r_bitpos];
    assign out_go  = i_res_ready;

    assign o_item_ready = (r_state == S_IDLE) && !r_clearing;
    assign item_take    = i_item_valid && o_item_ready;

    // Sequencer and memory control.
    always_comb begin
        n_state      = r_state;
        n_act        = r_act;
        n_idx        = r_idx;
        n_owner      = r_owner;
        n_word       = r_word;
        n_bitpos     = r_bitpos;
        n_vidx       = r_vidx;
        n_head       = r_head;
        n_tail       = r_tail;
        n_fill       = r_fill;
        n_free       = r_free;
        n_fin_status = r_fin_status;
        n_fin_index  = r_fin_index;
        bm_we    = 1'b0;
        bm_waddr = '0;
        bm_wdata = '0;
        bm_re    = 1'b0;
        bm_raddr = '0;
        oq_we    = 1'b0;
        oq_waddr = '0;
        oq_wdata = '0;
        oq_re    = 1'b0;
        oq_raddr = '0;
        vf_we    = 1'b0;
        vf_waddr = '0;
        vf_wdata = '0;
        vf_re    = 1'b0;
        vf_raddr = '0;
        o_res_valid = 1'b0;
        o_res       = '0;

        if (r_clearing) begin
            // Clearing pass after reset: one owner entry and one bitmap word a cycle.
            oq_we    = 1'b1;
            oq_waddr = r_clr_cnt;
            if (r_clr_cnt < IW'(NUM_WORDS)) begin
                bm_we    = 1'b1;
                bm_waddr = WA'(r_clr_cnt);
            end
        end

        case (r_state)
            S_IDLE: begin
                if (i_item_valid && o_item_ready) begin
                    n_act   = i_item.action;
                    n_idx   = i_item.bit_index;
                    n_owner = OWNER_WIDTH'(i_item.owner_id);
                    n_fin_index = i_item.bit_index[6:0];
                    n_fin_status = ST_OK;
                    if (i_item.action inside {ACT_MARK, ACT_CLEAR, ACT_TEST}) begin
                        if (32'(i_item.bit_index) >= NUM_BITS) begin
                            n_fin_status = ST_RANGE;
                            n_state      = S_FIN;
                        end else begin
                            n_bitpos = in_x[BW-1:0];
                            bm_re    = 1'b1;
                            bm_raddr = WA'(in_x >> BW);
                            oq_re    = 1'b1;
                            oq_raddr = IW'(in_x);
                            n_state  = S_BIT;
                        end
                    end else if (i_item.action == ACT_ALLOC) begin
                        n_word   = '0;
                        bm_re    = 1'b1;
                        bm_raddr = '0;
                        n_state  = S_SCAN;
                    end else if (i_item.action == ACT_POP) begin
                        if (r_fill == '0) begin
                            n_fin_index  = '0;
                            n_fin_status = ST_EMPTY;
                            n_state      = S_FIN;
                        end else begin
                            vf_re    = 1'b1;
                            vf_raddr = r_head;
                            n_state  = S_POPA;
                        end
                    end else begin
                        n_state = S_FIN;
                    end
                end
            end

            // Mark, clear or test with the addressed word in hand.
            S_BIT: begin
                if (out_go) begin
                    if (r_act == ACT_MARK && !bit_now) begin
                        bm_we    = 1'b1;
                        bm_waddr = WA'(XW'(r_idx) >> BW);
                        bm_wdata = bm_rdata | (ONE_W << r_bitpos);
                        n_free   = r_free - FW'(1);
                    end else if (r_act == ACT_CLEAR) begin
                        if (bit_now) begin
                            bm_we    = 1'b1;
                            bm_waddr = WA'(XW'(r_idx) >> BW);
                            bm_wdata = bm_rdata & ~(ONE_W << r_bitpos);
                            n_free   = r_free + FW'(1);
                        end
                        oq_we    = 1'b1;
                        oq_waddr = IW'(XW'(r_idx));
                        oq_wdata = {oq_rdata[OQW-1], {OWNER_WIDTH{1'b0}}};
                    end
                    o_res_valid        = 1'b1;
                    o_res.result_index = r_idx[6:0];
                    o_res.bit_value    = bit_now;
                    o_res.free_count   = 8'(n_free);
                    o_res.status       = ST_OK;
                    n_state            = S_IDLE;
                end
            end

            // One bitmap word per cycle while out_go; the next read as this is checked.
            S_SCAN: begin
                if (out_go) begin
                    if (scan_found) begin
                        bm_we    = 1'b1;
                        bm_waddr = r_word;
                        bm_wdata = bm_rdata | (ONE_W << scan_pos);
                        n_vidx   = IW'({r_word, scan_pos});
                        oq_re    = 1'b1;
                        oq_raddr = IW'({r_word, scan_pos});
                        n_state  = S_AWR;
                    end else if (r_word == LAST_WORD) begin
                        o_res_valid      = 1'b1;
                        o_res.free_count = 8'(r_free);
                        o_res.status     = ST_FULL;
                        n_state          = S_IDLE;
                    end else begin
                        n_word   = r_word + WA'(1);
                        bm_re    = 1'b1;
                        bm_raddr = r_word + WA'(1);
                    end
                end
            end

            // Store the owner and queue the frame unless it is already queued.
            S_AWR: begin
                if (out_go) begin
                    oq_we    = 1'b1;
                    oq_waddr = r_vidx;
                    oq_wdata = {1'b1, r_owner};
                    if (!oq_rdata[OQW-1]) begin
                        vf_we    = 1'b1;
                        vf_waddr = r_tail;
                        vf_wdata = r_vidx;
                        n_tail   = (r_tail == LAST_IDX) ? '0 : r_tail + IW'(1);
                        n_fill   = r_fill + FW'(1);
                    end
                    n_free             = r_free - FW'(1);
                    o_res_valid        = 1'b1;
                    o_res.result_index = 7'(r_vidx);
                    o_res.free_count   = 8'(n_free);
                    o_res.status       = ST_OK;
                    n_state            = S_IDLE;
                end
            end

            // Victim index in hand: dequeue it and fetch its owner and bit.
            S_POPA: begin
                n_vidx   = vf_rdata;
                n_bitpos = vf_x[BW-1:0];
                oq_re    = 1'b1;
                oq_raddr = vf_rdata;
                bm_re    = 1'b1;
                bm_raddr = WA'(vf_x >> BW);
                n_head   = (r_head == LAST_IDX) ? '0 : r_head + IW'(1);
                n_fill   = r_fill - FW'(1);
                n_state  = S_POPB;
            end

            S_POPB: begin
                if (out_go) begin
                    oq_we    = 1'b1;
                    oq_waddr = r_vidx;
                    oq_wdata = {1'b0, oq_rdata[OWNER_WIDTH-1:0]};
                    o_res_valid        = 1'b1;
                    o_res.result_index = 7'(r_vidx);
                    o_res.result_owner = 8'(oq_rdata[OWNER_WIDTH-1:0]);
                    o_res.bit_value    = bit_now;
                    o_res.free_count   = 8'(r_free);
                    o_res.status       = ST_OK;
                    n_state            = S_IDLE;
                end
            end

            // Results that need no memory: range errors, empty queue, unused codes.
            S_FIN: begin
                if (out_go) begin
                    o_res_valid        = 1'b1;
                    o_res.result_index = r_fin_index;
                    o_res.free_count   = 8'(r_free);
                    o_res.status       = r_fin_status;
                    n_state            = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_head     <= '0;
            r_tail     <= '0;
            r_fill     <= '0;
            r_free     <= FW'(NUM_BITS);
            r_clearing <= 1'b1;
            r_clr_cnt  <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_fill  <= n_fill;
            r_free  <= n_free;
            if (r_clearing) begin
                r_clr_cnt <= r_clr_cnt + IW'(1);
                if (r_clr_cnt == LAST_IDX) begin
                    r_clearing <= 1'b0;
                end
            end
        end
    end

    // Per-item working registers.
    always_ff @(posedge i_clk) begin
        r_act        <= n_act;
        r_idx        <= n_idx;
        r_owner      <= n_owner;
        r_word       <= n_word;
        r_bitpos     <= n_bitpos;
        r_vidx       <= n_vidx;
        r_fin_status <= n_fin_status;
        r_fin_index  <= n_fin_index;
    end

    `BAFV_NEVER(a_free_range, r_free > FW'(NUM_BITS), "free count above map size")
    `BAFV_NEVER(a_fill_range, r_fill > FW'(NUM_BITS), "victim queue fill above map size")
    `BAFV_NEVER(a_empty_ptrs, (r_fill == '0) && (r_head != r_tail), "pointers apart when empty")
    `BAFV_ASSERT(a_busy_after_accept, item_take |=> !o_item_ready, "second word taken while busy")
    `BAFV_NEVER(a_res_stall, o_res_valid && !i_res_ready, "result into a full output stage")

endmodule

@@ design/bitmap_allocator_fifo_victim_top.sv @@
// Top level of the frame allocator: stream ports, word packing and the output register.
// Depends on bafv_pkg and bafv_engine.
//
// Frame allocator with a used/free bitmap, an owner tag per frame and a FIFO of
// allocated frames that supplies replacement victims. After reset the block runs a
// clearing pass over every owner entry and bitmap word and takes no request word
// until it ends. Items are handled one at a time. Mark, clear and test read the
// addressed bitmap word and owner entry first; range errors, an empty-queue pop and
// unused action codes need no memory. Pop reads the victim FIFO, followed by the
// owner and bitmap memories. Allocate scans the bitmap memory one WORD_BITS-wide
// word per cycle while the output register can take a result, then the owner entry
// is read and written back. A result waits in the output register while the next
// request is accepted. WORD_BITS must be a power of two.
module bitmap_allocator_fifo_victim_top
    import bafv_pkg::*;
#(
    parameter int NUM_BITS    = NUM_BITS_DEF,
    parameter int WORD_BITS   = WORD_BITS_DEF,
    parameter int OWNER_WIDTH = OWNER_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // bit_index [7:0], owner_id [15:8]
    input  logic [2:0]  s_axis_tuser,  // action [2:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,  // result_index [6:0], result_owner [14:7],
                                       // bit_value [15], free_count [23:16]
    output logic [1:0]  m_axis_tuser   // status [1:0]
);

    t_item   item;
    t_result eng_res;
    t_result r_out;
    logic    eng_res_valid;
    logic    out_free;
    logic    r_out_valid;

    // Unpack the request word.
    assign item.action    = s_axis_tuser;
    assign item.bit_index = s_axis_tdata[7:0];
    assign item.owner_id  = s_axis_tdata[15:8];

    assign out_free = !r_out_valid || m_axis_tready;

    bafv_engine #(
        .NUM_BITS    (NUM_BITS),
        .WORD_BITS   (WORD_BITS),
        .OWNER_WIDTH (OWNER_WIDTH)
    ) u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (s_axis_tvalid),
        .o_item_ready (s_axis_tready),
        .i_item       (item),
        .o_res_valid  (eng_res_valid),
        .i_res_ready  (out_free),
        .o_res        (eng_res)
    );

    // Output register between the engine and the response stream.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (eng_res_valid) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (eng_res_valid) begin
            r_out <= eng_res;
        end
    end

    // Pack the response word.
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out.free_count, r_out.bit_value,
                            r_out.result_owner, r_out.result_index};
    assign m_axis_tuser  = r_out.status;

endmodule

@@ tb/sv/bafv_frame_checker.sv @@
`timescale 1ns / 100ps
// Scoreboard for the frame allocator: watches the request and response streams and
// keeps its own bitmap, owner table and victim queue to predict every response word.
// Depends on bafv_pkg.
module bafv_frame_checker
    import bafv_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_tvalid,
    input  logic        i_req_tready,
    input  logic [15:0] i_req_tdata,  // bit_index [7:0], owner_id [15:8]
    input  logic [2:0]  i_req_tuser,  // action [2:0]
    input  logic        i_rsp_tvalid,
    input  logic        i_rsp_tready,
    input  logic [23:0] i_rsp_tdata,  // result_index [6:0], result_owner [14:7],
                                      // bit_value [15], free_count [23:16]
    input  logic [1:0]  i_rsp_tuser,  // status [1:0]
    output int          o_err_count,
    output int          o_pending
);

    localparam int FRAMES = NUM_BITS_DEF;

    // Shadow copy of the allocator state.
    logic [FRAMES-1:0] used_map;
    logic [FRAMES-1:0] queued_map;
    logic [7:0]        frame_owner [FRAMES];
    logic [6:0]        victim_ring [FRAMES];
    logic [6:0]        ring_head;
    logic [6:0]        ring_tail;
    logic [7:0]        ring_fill;

    // Predicted response words, oldest first.
    t_result           expected_replies [$];

    initial begin
        o_err_count = 0;
        o_pending   = 0;
    end

    // Print one line per problem and keep count of them.
    task automatic report_mismatch(string what);
        $display("[%0t] frame checker: %s", $time, what);
        o_err_count++;
    endtask

    // Apply one request to the shadow state and return the response it must produce.
    function automatic t_result apply_request(t_item req);
        t_result r;
        int      slot;
        r              = '0;
        r.result_index = req.bit_index[6:0];
        r.status       = ST_OK;
        case (req.action)
            ACT_MARK, ACT_CLEAR, ACT_TEST: begin
                if (req.bit_index >= FRAMES) begin
                    r.status = ST_RANGE;
                end else begin
                    r.bit_value = used_map[req.bit_index];
                    if (req.action == ACT_MARK) begin
                        used_map[req.bit_index] = 1'b1;
                    end else if (req.action == ACT_CLEAR) begin
                        // A cleared frame stays queued if it was queued.
                        used_map[req.bit_index]    = 1'b0;
                        frame_owner[req.bit_index] = '0;
                    end
                end
            end
            ACT_ALLOC: begin
                r.result_index = '0;
                slot = -1;
                for (int i = FRAMES - 1; i >= 0; i--) begin
                    if (!used_map[i]) slot = i;
                end
                if (slot < 0) begin
                    r.status = ST_FULL;
                end else begin
                    used_map[slot]    = 1'b1;
                    frame_owner[slot] = req.owner_id;
                    // A frame enters the victim queue only if it is not already queued.
                    if (!queued_map[slot]) begin
                        queued_map[slot]       = 1'b1;
                        victim_ring[ring_tail] = slot[6:0];
                        ring_tail++;
                        ring_fill++;
                    end
                    r.result_index = slot[6:0];
                end
            end
            ACT_POP: begin
                r.result_index = '0;
                if (ring_fill == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    // Popping leaves the used bit and the owner as they are.
                    slot = victim_ring[ring_head];
                    ring_head++;
                    ring_fill--;
                    queued_map[slot] = 1'b0;
                    r.result_index   = slot[6:0];
                    r.result_owner   = frame_owner[slot];
                    r.bit_value      = used_map[slot];
                end
            end
            default: begin
                // Spare action codes only echo the index and the free count.
            end
        endcase
        r.free_count = 8'(FRAMES - $countones(used_map));
        return r;
    endfunction

    // Compare each response word, then predict for each request word.
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        t_item   req;
        if (!i_rst_n) begin
            used_map   = '0;
            queued_map = '0;
            ring_head  = '0;
            ring_tail  = '0;
            ring_fill  = '0;
            for (int i = 0; i < FRAMES; i++) frame_owner[i] = '0;
            expected_replies.delete();
        end else begin
            if (i_rsp_tvalid && i_rsp_tready) begin
                got.result_index = i_rsp_tdata[6:0];
                got.result_owner = i_rsp_tdata[14:7];
                got.bit_value    = i_rsp_tdata[15];
                got.free_count   = i_rsp_tdata[23:16];
                got.status       = i_rsp_tuser;
                if (expected_replies.size() == 0) begin
                    report_mismatch("response word with no request outstanding");
                end else begin
                    want = expected_replies.pop_front();
                    if (got.result_index !== want.result_index)
                        report_mismatch($sformatf("result_index %0d, expected %0d",
                            got.result_index, want.result_index));
                    if (got.result_owner !== want.result_owner)
                        report_mismatch($sformatf("result_owner %0d, expected %0d",
                            got.result_owner, want.result_owner));
                    if (got.bit_value !== want.bit_value)
                        report_mismatch($sformatf("bit_value %0d, expected %0d",
                            got.bit_value, want.bit_value));
                    if (got.free_count !== want.free_count)
                        report_mismatch($sformatf("free_count %0d, expected %0d",
                            got.free_count, want.free_count));
                    if (got.status !== want.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                            got.status, want.status));
                end
            end
            if (i_req_tvalid && i_req_tready) begin
                req.action    = i_req_tuser;
                req.bit_index = i_req_tdata[7:0];
                req.owner_id  = i_req_tdata[15:8];
                expected_replies.push_back(apply_request(req));
            end
        end
        o_pending <= expected_replies.size();
    end

endmodule

@@ tb/sv/bitmap_allocator_fifo_victim_top_tb.sv @@
`timescale 1ns / 100ps
// Testbench top for the frame allocator: clock, reset, request and response traffic.
// Depends on bafv_pkg, bitmap_allocator_fifo_victim_top and bafv_frame_checker.
module bitmap_allocator_fifo_victim_top_tb;
    import bafv_pkg::*;

    // Worst case is about 1500 words, each with the longest request gap, the longest allocate
    // and the longest response stall, plus the clearing pass and the long hold; the limit leaves several times that.
    localparam int RUN_LIMIT    = 400000;
    localparam int RANDOM_WORDS = 1450;
    localparam int LONG_HOLD    = 400;
    localparam int HOLD_AT      = 300;

    // Action codes the block does not use.
    localparam logic [2:0] ACT_SPARE_A = 3'd5;
    localparam logic [2:0] ACT_SPARE_B = 3'd6;
    localparam logic [2:0] ACT_SPARE_C = 3'd7;

    // Kinds of random stretch.
    typedef enum int {EP_FILL, EP_DRAIN, EP_MIXED, EP_SCATTER} t_episode;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;   // bit_index [7:0], owner_id [15:8]
    logic [2:0]  s_axis_tuser;   // action [2:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;   // result_index [6:0], result_owner [14:7],
                                 // bit_value [15], free_count [23:16]
    logic [1:0]  m_axis_tuser;   // status [1:0]

    int          err_count;
    int          pending;
    int          cycle_count = 0;
    int          rx_seen;
    int          rx_hold;
    bit          tx_idle;
    bit          rx_idle;

    bitmap_allocator_fifo_victim_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    bafv_frame_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_tvalid (s_axis_tvalid),
        .i_req_tready (s_axis_tready),
        .i_req_tdata  (s_axis_tdata),
        .i_req_tuser  (s_axis_tuser),
        .i_rsp_tvalid (m_axis_tvalid),
        .i_rsp_tready (m_axis_tready),
        .i_rsp_tdata  (m_axis_tdata),
        .i_rsp_tuser  (m_axis_tuser),
        .o_err_count  (err_count),
        .o_pending    (pending)
    );

    // 4 ns clock.
    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // Run limit.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > RUN_LIMIT) begin
            $display("bitmap_allocator_fifo_victim_top_tb: FAIL");
            $finish;
        end
    end

    // Offer one request word, after a random gap while tx_idle is set, and wait until it is taken.
    task automatic send_word(logic [2:0] act, logic [7:0] idx, logic [7:0] tag);
        int gap;
        gap = tx_idle ? $urandom_range(0, 19) : 0;
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {tag, idx};
        s_axis_tuser  <= act;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Response side: a random stall after each word, quiet stretches, and one long
    // hold-off so that the block backs up into its request port.
    initial begin
        m_axis_tready <= 1'b0;
        rx_seen = 0;
        rx_hold = 0;
        rx_idle = 1'b1;
        wait (i_rst_n);
        @(posedge i_clk);
        m_axis_tready <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready) begin
                rx_seen++;
                if (rx_seen % 100 == 0) rx_idle = ($urandom_range(0, 3) != 0);
                if (rx_seen == HOLD_AT)
                    rx_hold = LONG_HOLD;
                else
                    rx_hold = rx_idle ? $urandom_range(0, 19) : 0;
                if (rx_hold != 0) m_axis_tready <= 1'b0;
            end else if (rx_hold != 0) begin
                rx_hold--;
                if (rx_hold == 0) m_axis_tready <= 1'b1;
            end
        end
    end

    // Request side and verdict.
    initial begin
        t_episode    mode;
        int          span;
        int          roll;
        int          sent;
        logic [2:0]  act;
        logic [7:0]  idx;

        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= ACT_MARK;
        i_rst_n       <= 1'b0;
        tx_idle = 1'b1;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: empty queue, field extremes, out-of-range indexes, clearing a
        // queued frame, re-allocating a queued frame and the spare action codes.
        send_word(ACT_POP,     8'd0,   8'd0);
        send_word(ACT_TEST,    8'd0,   8'd0);
        send_word(ACT_ALLOC,   8'd0,   8'hFF);
        send_word(ACT_ALLOC,   8'hFF,  8'd0);
        send_word(ACT_MARK,    8'd127, 8'd0);
        send_word(ACT_MARK,    8'd127, 8'hFF);
        send_word(ACT_TEST,    8'd127, 8'd0);
        send_word(ACT_MARK,    8'd128, 8'd0);
        send_word(ACT_CLEAR,   8'd255, 8'd0);
        send_word(ACT_TEST,    8'd255, 8'hFF);
        send_word(ACT_CLEAR,   8'd0,   8'd0);
        send_word(ACT_ALLOC,   8'd0,   8'hA5);
        send_word(ACT_POP,     8'd0,   8'd0);
        send_word(ACT_CLEAR,   8'd1,   8'd0);
        send_word(ACT_POP,     8'd0,   8'd0);
        send_word(ACT_POP,     8'd0,   8'd0);
        send_word(ACT_SPARE_A, 8'h55,  8'hAA);
        send_word(ACT_SPARE_B, 8'hAA,  8'h55);
        send_word(ACT_SPARE_C, 8'hFF,  8'hFF);
        send_word(ACT_CLEAR,   8'd127, 8'd0);
        send_word(ACT_TEST,    8'd64,  8'd0);

        // Random part in stretches of one kind: filling runs the map full, draining
        // empties the queue, the others scatter single-frame actions and noise.
        sent = 0;
        while (sent < RANDOM_WORDS) begin
            mode    = t_episode'($urandom_range(0, 3));
            span    = (mode == EP_FILL) ? $urandom_range(140, 220) : $urandom_range(20, 120);
            tx_idle = ($urandom_range(0, 3) != 0);
            for (int n = 0; n < span && sent < RANDOM_WORDS; n++) begin
                roll = $urandom_range(0, 99);
                case (mode)
                    EP_FILL:
                        act = (roll < 85) ? ACT_ALLOC : (roll < 93) ? ACT_POP : ACT_TEST;
                    EP_DRAIN:
                        act = (roll < 40) ? ACT_CLEAR : (roll < 85) ? ACT_POP : ACT_TEST;
                    EP_MIXED:
                        act = 3'($urandom_range(0, 7));
                    default:
                        act = (roll < 35) ? ACT_MARK : (roll < 70) ? ACT_CLEAR :
                              (roll < 90) ? ACT_TEST : ACT_ALLOC;
                endcase
                if (mode == EP_MIXED || $urandom_range(0, 9) == 0)
                    idx = 8'($urandom);
                else
                    idx = 8'($urandom_range(0, NUM_BITS_DEF - 1));
                send_word(act, idx, 8'($urandom));
                sent++;
            end
        end
        s_axis_tvalid <= 1'b0;

        // Drain the outstanding responses, then allow for the longest latency.
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        if (err_count == 0) begin
            $display("bitmap_allocator_fifo_victim_top_tb: PASS");
        end else begin
            $display("bitmap_allocator_fifo_victim_top_tb: FAIL");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+design
design/bafv_pkg.sv
design/bafv_ram.sv
design/bafv_ffz.sv
design/bafv_engine.sv
design/bitmap_allocator_fifo_victim_top.sv
tb/sv/bafv_frame_checker.sv
tb/sv/bitmap_allocator_fifo_victim_top_tb.sv
